[design/assert_macros.svh]
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define LOM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, on the usual clk_i / rst_ni pair.
`define LOM_ASSERT_CLK(lbl, prop, msg) `LOM_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

[design/lom_pkg.sv]
package lom_pkg;

  localparam int unsigned MAX_ITEMS = 256;
  localparam int unsigned DEPTH     = MAX_ITEMS + 2;
  localparam int unsigned ID_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam int unsigned OP_W     = 3;
  localparam int unsigned ITEM_W   = 9;
  localparam int unsigned STATUS_W = 2;

  // left sentinel and right sentinel link indexes
  localparam logic [ID_W-1:0] LSENT = '0;
  localparam logic [ID_W-1:0] RSENT = ID_W'(MAX_ITEMS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_MOVE_RIGHT = 3'd1,
    OP_MOVE_LEFT  = 3'd2,
    OP_SWAP       = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_READ       = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD      = 2'd1,
    ST_PAST_END = 2'd2
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ITEM_W-1:0] item_x;
    logic [ITEM_W-1:0] item_y;
  } in_item_t;

  typedef struct packed {
    logic [ITEM_W-1:0]   read_value;
    logic [STATUS_W-1:0] status;
    logic                last_in_order;
  } out_item_t;

  // one read per link memory per cycle, one link pair written per cycle:
  // right_link[wr_a] = wr_b, left_link[wr_b] = wr_a
  typedef struct packed {
    logic [ID_W-1:0] rd_left_addr;
    logic [ID_W-1:0] rd_right_addr;
    logic            wr_en;
    logic [ID_W-1:0] wr_a;
    logic [ID_W-1:0] wr_b;
  } link_req_t;

  typedef struct packed {
    logic [ID_W-1:0] rd_left_data;
    logic [ID_W-1:0] rd_right_data;
    logic [ID_W-1:0] head;   // right_link of the left sentinel
    logic [ID_W-1:0] tail;   // left_link of the right sentinel
  } link_rsp_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_CHECK,
    CS_RD_Y,
    CS_PLAN,
    CS_WRITE,
    CS_RD_NX,
    CS_RD_END,
    CS_DONE
  } ctrl_state_e;

endpackage

[design/lom_links.sv]
module lom_links (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lom_pkg::link_req_t  req_i,
  output lom_pkg::link_rsp_t  rsp_o
);

  logic [lom_pkg::ID_W-1:0] left_mem  [lom_pkg::DEPTH];
  logic [lom_pkg::ID_W-1:0] right_mem [lom_pkg::DEPTH];

  // sentinel links live in flops so that reset links them
  logic [lom_pkg::ID_W-1:0] head_q;
  logic [lom_pkg::ID_W-1:0] tail_q;

  logic [lom_pkg::ID_W-1:0] left_rd_q;
  logic [lom_pkg::ID_W-1:0] right_rd_q;
  logic                     left_sent_q;
  logic                     right_sent_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      right_mem[req_i.wr_a] <= req_i.wr_b;
      left_mem[req_i.wr_b]  <= req_i.wr_a;
    end
  end

  always_ff @(posedge clk_i) begin
    left_rd_q    <= left_mem[req_i.rd_left_addr];
    right_rd_q   <= right_mem[req_i.rd_right_addr];
    left_sent_q  <= (req_i.rd_left_addr == lom_pkg::RSENT);
    right_sent_q <= (req_i.rd_right_addr == lom_pkg::LSENT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= lom_pkg::RSENT;
      tail_q <= lom_pkg::LSENT;
    end else if (req_i.wr_en) begin
      if (req_i.wr_a == lom_pkg::LSENT) begin
        head_q <= req_i.wr_b;
      end
      if (req_i.wr_b == lom_pkg::RSENT) begin
        tail_q <= req_i.wr_a;
      end
    end
  end

  assign rsp_o.rd_left_data  = left_sent_q  ? tail_q : left_rd_q;
  assign rsp_o.rd_right_data = right_sent_q ? head_q : right_rd_q;
  assign rsp_o.head          = head_q;
  assign rsp_o.tail          = tail_q;

endmodule

[design/lom_ctrl.sv]
module lom_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  lom_pkg::in_item_t   cmd_i,
  output logic                idle_o,
  output logic                done_o,
  input  logic                done_ack_i,
  output lom_pkg::out_item_t  res_o,
  output lom_pkg::link_req_t  link_req_o,
  input  lom_pkg::link_rsp_t  link_rsp_i
);

  lom_pkg::ctrl_state_e state_q, state_d;
  lom_pkg::in_item_t    cmd_q, cmd_d;
  lom_pkg::out_item_t   res_q, res_d;

  logic                      reversed_q, reversed_d;
  logic [lom_pkg::ID_W-1:0]  cursor_q, cursor_d;
  logic [lom_pkg::CNT_W-1:0] count_q, count_d;
  logic [lom_pkg::DEPTH-1:0] present_q, present_d;

  logic [lom_pkg::ID_W-1:0] xl_q, xl_d, xr_q, xr_d;
  logic [lom_pkg::ID_W-1:0] pa_q [4];
  logic [lom_pkg::ID_W-1:0] pa_d [4];
  logic [lom_pkg::ID_W-1:0] pb_q [4];
  logic [lom_pkg::ID_W-1:0] pb_d [4];
  logic [1:0]               last_idx_q, last_idx_d;
  logic [1:0]               widx_q, widx_d;

  logic [lom_pkg::ID_W-1:0] x_id, y_id, front, back, step_data, yl, yr;
  logic x_rng, y_rng, x_ok, y_ok, pair_ok, app_ok, to_right, wr_last, past_end;

  assign x_id  = lom_pkg::ID_W'(cmd_q.item_x);
  assign y_id  = lom_pkg::ID_W'(cmd_q.item_y);
  assign x_rng = (cmd_q.item_x != '0) &&
                 (cmd_q.item_x <= lom_pkg::ITEM_W'(lom_pkg::MAX_ITEMS));
  assign y_rng = (cmd_q.item_y != '0) &&
                 (cmd_q.item_y <= lom_pkg::ITEM_W'(lom_pkg::MAX_ITEMS));
  assign x_ok    = x_rng && present_q[x_id];
  assign y_ok    = y_rng && present_q[y_id];
  assign pair_ok = (cmd_q.item_x != cmd_q.item_y) && x_ok && y_ok;
  assign app_ok  = x_rng && !present_q[x_id] &&
                   (count_q < lom_pkg::CNT_W'(lom_pkg::MAX_ITEMS));

  assign front     = reversed_q ? lom_pkg::RSENT : lom_pkg::LSENT;
  assign back      = reversed_q ? lom_pkg::LSENT : lom_pkg::RSENT;
  assign step_data = reversed_q ? link_rsp_i.rd_left_data : link_rsp_i.rd_right_data;
  assign past_end  = (step_data == back) || (step_data > lom_pkg::RSENT);
  assign to_right  = (cmd_q.op == lom_pkg::OP_MOVE_RIGHT) ^ reversed_q;
  assign wr_last   = (widx_q == last_idx_q);
  assign yl        = link_rsp_i.rd_left_data;
  assign yr        = link_rsp_i.rd_right_data;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lom_pkg::CS_IDLE: begin
        if (start_i) state_d = lom_pkg::CS_CHECK;
      end
      lom_pkg::CS_CHECK: begin
        unique case (cmd_q.op) inside
          lom_pkg::OP_READ:   state_d = lom_pkg::CS_RD_NX;
          lom_pkg::OP_APPEND: state_d = app_ok ? lom_pkg::CS_WRITE : lom_pkg::CS_DONE;
          lom_pkg::OP_MOVE_RIGHT, lom_pkg::OP_MOVE_LEFT, lom_pkg::OP_SWAP:
            state_d = pair_ok ? lom_pkg::CS_RD_Y : lom_pkg::CS_DONE;
          default:            state_d = lom_pkg::CS_DONE;
        endcase
      end
      lom_pkg::CS_RD_Y:   state_d = lom_pkg::CS_PLAN;
      lom_pkg::CS_PLAN:   state_d = lom_pkg::CS_WRITE;
      lom_pkg::CS_WRITE: begin
        if (wr_last) state_d = lom_pkg::CS_DONE;
      end
      lom_pkg::CS_RD_NX:  state_d = past_end ? lom_pkg::CS_DONE : lom_pkg::CS_RD_END;
      lom_pkg::CS_RD_END: state_d = lom_pkg::CS_DONE;
      lom_pkg::CS_DONE: begin
        if (done_ack_i) state_d = lom_pkg::CS_IDLE;
      end
      default:            state_d = lom_pkg::CS_IDLE;
    endcase
  end

  // datapath and link port
  always_comb begin
    cmd_d      = cmd_q;
    res_d      = res_q;
    reversed_d = reversed_q;
    cursor_d   = cursor_q;
    count_d    = count_q;
    present_d  = present_q;
    xl_d       = xl_q;
    xr_d       = xr_q;
    pa_d       = pa_q;
    pb_d       = pb_q;
    last_idx_d = last_idx_q;
    widx_d     = widx_q;

    link_req_o.rd_left_addr  = x_id;
    link_req_o.rd_right_addr = x_id;
    link_req_o.wr_en         = 1'b0;
    link_req_o.wr_a          = pa_q[widx_q];
    link_req_o.wr_b          = pb_q[widx_q];

    unique case (state_q)
      lom_pkg::CS_IDLE: begin
        if (start_i) cmd_d = cmd_i;
      end
      lom_pkg::CS_CHECK: begin
        res_d = '0;
        widx_d = '0;
        if (cmd_q.op == lom_pkg::OP_READ) begin
          link_req_o.rd_left_addr  = cursor_q;
          link_req_o.rd_right_addr = cursor_q;
        end
        unique case (cmd_q.op) inside
          lom_pkg::OP_READ: ;
          lom_pkg::OP_REVERSE: begin
            reversed_d = !reversed_q;
            cursor_d   = back;  // front of the new direction
          end
          lom_pkg::OP_APPEND: begin
            if (app_ok) begin
              present_d[x_id] = 1'b1;
              count_d         = count_q + lom_pkg::CNT_W'(1);
              last_idx_d      = 2'd1;
              if (reversed_q) begin
                pa_d[0] = x_id;           pb_d[0] = link_rsp_i.head;
                pa_d[1] = lom_pkg::LSENT; pb_d[1] = x_id;
              end else begin
                pa_d[0] = link_rsp_i.tail; pb_d[0] = x_id;
                pa_d[1] = x_id;            pb_d[1] = lom_pkg::RSENT;
              end
            end else begin
              res_d.status = lom_pkg::ST_BAD;
            end
          end
          lom_pkg::OP_MOVE_RIGHT, lom_pkg::OP_MOVE_LEFT, lom_pkg::OP_SWAP: begin
            if (!pair_ok) res_d.status = lom_pkg::ST_BAD;
          end
          default: res_d.status = lom_pkg::ST_BAD;
        endcase
      end
      lom_pkg::CS_RD_Y: begin
        link_req_o.rd_left_addr  = y_id;
        link_req_o.rd_right_addr = y_id;
        xl_d = link_rsp_i.rd_left_data;
        xr_d = link_rsp_i.rd_right_data;
      end
      lom_pkg::CS_PLAN: begin
        widx_d     = '0;
        last_idx_d = 2'd2;
        if (cmd_q.op == lom_pkg::OP_SWAP) begin
          if (xr_q == y_id) begin
            // x directly left of y
            pa_d[0] = xl_q; pb_d[0] = y_id;
            pa_d[1] = y_id; pb_d[1] = x_id;
            pa_d[2] = x_id; pb_d[2] = yr;
          end else if (xl_q == y_id) begin
            // x directly right of y
            pa_d[0] = yl;   pb_d[0] = x_id;
            pa_d[1] = x_id; pb_d[1] = y_id;
            pa_d[2] = y_id; pb_d[2] = xr_q;
          end else begin
            last_idx_d = 2'd3;
            pa_d[0] = xl_q; pb_d[0] = y_id;
            pa_d[1] = y_id; pb_d[1] = xr_q;
            pa_d[2] = yl;   pb_d[2] = x_id;
            pa_d[3] = x_id; pb_d[3] = yr;
          end
        end else if (to_right) begin
          // neighbor right of y as seen after x is unlinked
          pa_d[0] = xl_q; pb_d[0] = xr_q;
          pa_d[1] = y_id; pb_d[1] = x_id;
          pa_d[2] = x_id; pb_d[2] = (xl_q == y_id) ? xr_q : yr;
        end else begin
          pa_d[0] = xl_q; pb_d[0] = xr_q;
          pa_d[1] = (xr_q == y_id) ? xl_q : yl; pb_d[1] = x_id;
          pa_d[2] = x_id; pb_d[2] = y_id;
        end
      end
      lom_pkg::CS_WRITE: begin
        link_req_o.wr_en = 1'b1;
        widx_d = widx_q + 2'd1;
        if (wr_last) cursor_d = front;
      end
      lom_pkg::CS_RD_NX: begin
        link_req_o.rd_left_addr  = step_data;
        link_req_o.rd_right_addr = step_data;
        if (past_end) begin
          res_d.status = lom_pkg::ST_PAST_END;
          cursor_d     = front;
        end else begin
          res_d.read_value = lom_pkg::ITEM_W'(step_data);
          cursor_d         = step_data;
        end
      end
      lom_pkg::CS_RD_END: begin
        res_d.last_in_order = (step_data == back);
      end
      lom_pkg::CS_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lom_pkg::CS_IDLE;
      reversed_q <= 1'b0;
      cursor_q   <= lom_pkg::LSENT;
      count_q    <= '0;
      present_q  <= '0;
    end else begin
      state_q    <= state_d;
      reversed_q <= reversed_d;
      cursor_q   <= cursor_d;
      count_q    <= count_d;
      present_q  <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    res_q      <= res_d;
    xl_q       <= xl_d;
    xr_q       <= xr_d;
    pa_q       <= pa_d;
    pb_q       <= pb_d;
    last_idx_q <= last_idx_d;
    widx_q     <= widx_d;
  end

  assign idle_o = (state_q == lom_pkg::CS_IDLE);
  assign done_o = (state_q == lom_pkg::CS_DONE);
  assign res_o  = res_q;

endmodule

[design/linked_order_move_swap_reverse_core.sv]
// Ordered id list with append, move, swap, reverse and read.
//
// Input channel: in_valid_i / in_stall_o carry one command (op, item_x,
// item_y) per transfer. Output channel: out_valid_o / out_stall_i carry
// exactly one result (read_value, status, last_in_order) per command,
// in command order.
//
// One command is worked on at a time; the input stalls from a transfer
// until the result has moved into the output register. The link memories
// give one registered read and one link pair write per cycle; append writes
// two link pairs, a move or an adjacent swap three, any other swap four, and
// a read steps the cursor, then, unless past the end, looks one id further on.
// The result shows on out_valid_o once the output register has taken it.
// While a result waits on out_stall_i the next command is still taken and
// worked on; it then holds in its last state until the output register frees.
//
// Reset empties the list, links the sentinels, clears the reversed flag and
// rewinds the read cursor. Link entries of ids never appended are never
// read, so the link memories need no clearing pass.
module linked_order_move_swap_reverse_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lom_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lom_pkg::out_item_t  out_item_o
);

  logic               idle, done, load;
  lom_pkg::out_item_t res;
  lom_pkg::link_req_t link_req;
  lom_pkg::link_rsp_t link_rsp;

  logic               out_valid_q;
  lom_pkg::out_item_t out_q;

  // busy sequencer stalls the input
  assign in_stall_o = !idle;

  // the output register takes a finished result when empty or draining
  assign load = done && (!out_valid_q || !out_stall_i);

  lom_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i && idle),
    .cmd_i      (in_item_i),
    .idle_o     (idle),
    .done_o     (done),
    .done_ack_i (load),
    .res_o      (res),
    .link_req_o (link_req),
    .link_rsp_i (link_rsp)
  );

  lom_links u_links (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (link_req),
    .rsp_o  (link_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[design/lom_checker.sv]
`include "assert_macros.svh"

module lom_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lom_pkg::out_item_t out_item_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // a stalled result stays put
  `LOM_ASSERT_CLK(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o),
    "stalled result changed")

  // one command at a time: input stalls right after a transfer
  `LOM_ASSERT_CLK(a_busy_after_xfer, in_xfer |=> in_stall_o,
    "input not stalled after transfer")

  // failed commands carry no id
  `LOM_ASSERT_CLK(a_err_clean,
    out_valid_o && (out_item_o.status != lom_pkg::ST_OK) |->
      (out_item_o.read_value == '0) && !out_item_o.last_in_order,
    "error result carries data")

  // end-of-order flag only with a real id
  `LOM_ASSERT_CLK(a_last_has_id,
    out_valid_o && out_item_o.last_in_order |->
      (out_item_o.status == lom_pkg::ST_OK) && (out_item_o.read_value != '0),
    "last flag without id")

endmodule

bind linked_order_move_swap_reverse_core lom_checker u_lom_checker (.*);

[test/tb_linked_order_move_swap_reverse_core.sv]
module tb_linked_order_move_swap_reverse_core;
  timeunit 1ns;
  timeprecision 1ps;

  // ops 6 and 7 have no meaning; the block must answer them with a bad status
  localparam logic [lom_pkg::OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [lom_pkg::OP_W-1:0] OP_UNDEF_HI = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SHOW_LIMIT  = 40;

  // canned results for rows whose answer is obvious
  localparam lom_pkg::out_item_t R_OK   = '{'0, lom_pkg::ST_OK, 1'b0};
  localparam lom_pkg::out_item_t R_BAD  = '{'0, lom_pkg::ST_BAD, 1'b0};
  localparam lom_pkg::out_item_t R_PAST = '{'0, lom_pkg::ST_PAST_END, 1'b0};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lom_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall_i = 1'b0;
  lom_pkg::out_item_t out_item;

  always #2 clk_i = ~clk_i;

  linked_order_move_swap_reverse_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item)
  );

  // ---------------------------------------------------------------------------
  // Order predictor: its own copy of the link memories, presence bits,
  // direction flag and read cursor.
  // ---------------------------------------------------------------------------
  logic [lom_pkg::ID_W-1:0] ord_left  [lom_pkg::DEPTH];
  logic [lom_pkg::ID_W-1:0] ord_right [lom_pkg::DEPTH];
  bit                       on_list   [lom_pkg::DEPTH];
  bit                       rev_q;
  int unsigned              loaded;
  logic [lom_pkg::ID_W-1:0] cursor;
  logic [lom_pkg::ID_W-1:0] listed [$];   // ids on the list, in append order

  lom_pkg::out_item_t pending_results [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned gap_pct;          // idle chance for both sides, 0 = no idling
  int unsigned hold_cnt;         // receiver stall burst left
  int unsigned read_run;         // reads still owed by a read burst

  function automatic void order_reset();
    foreach (on_list[i]) begin
      on_list[i]   = 1'b0;
      ord_left[i]  = '0;
      ord_right[i] = '0;
    end
    ord_right[lom_pkg::LSENT] = lom_pkg::RSENT;
    ord_left[lom_pkg::RSENT]  = lom_pkg::LSENT;
    rev_q  = 1'b0;
    loaded = 0;
    cursor = lom_pkg::LSENT;
    listed.delete();
  endfunction

  function automatic void link_ids(logic [lom_pkg::ID_W-1:0] a,
                                   logic [lom_pkg::ID_W-1:0] b);
    ord_right[a] = b;
    ord_left[b]  = a;
  endfunction

  function automatic bit id_live(logic [lom_pkg::ITEM_W-1:0] id);
    return id >= 1 && id <= lom_pkg::MAX_ITEMS && on_list[id];
  endfunction

  // Applies one command to the predicted list and returns its result.
  function automatic lom_pkg::out_item_t order_apply(lom_pkg::in_item_t c);
    lom_pkg::out_item_t       r;
    logic [lom_pkg::ID_W-1:0] x, y, nx, fr, en, xl, xr, yl, yr, nb;
    r  = R_OK;
    x  = c.item_x;
    y  = c.item_y;
    fr = rev_q ? lom_pkg::RSENT : lom_pkg::LSENT;
    en = rev_q ? lom_pkg::LSENT : lom_pkg::RSENT;
    case (c.op)
      lom_pkg::OP_READ: begin
        nx = rev_q ? ord_left[cursor] : ord_right[cursor];
        if (nx == en || nx >= lom_pkg::DEPTH) begin
          // walked off the end: report it and start over
          r.status = lom_pkg::ST_PAST_END;
          cursor   = fr;
        end else begin
          r.read_value    = nx;
          cursor          = nx;
          r.last_in_order = ((rev_q ? ord_left[nx] : ord_right[nx]) == en);
        end
      end
      lom_pkg::OP_REVERSE: rev_q = ~rev_q;
      lom_pkg::OP_APPEND: begin
        if (x < 1 || x > lom_pkg::MAX_ITEMS || on_list[x] ||
            loaded >= lom_pkg::MAX_ITEMS) begin
          r.status = lom_pkg::ST_BAD;
        end else begin
          on_list[x] = 1'b1;
          loaded++;
          listed.push_back(x);
          // tail of the current order sits next to the end sentinel
          if (rev_q) begin
            nb = ord_right[lom_pkg::LSENT];
            link_ids(x, nb);
            link_ids(lom_pkg::LSENT, x);
          end else begin
            nb = ord_left[lom_pkg::RSENT];
            link_ids(nb, x);
            link_ids(x, lom_pkg::RSENT);
          end
        end
      end
      lom_pkg::OP_MOVE_RIGHT, lom_pkg::OP_MOVE_LEFT, lom_pkg::OP_SWAP: begin
        if (x == y || !id_live(x) || !id_live(y)) begin
          r.status = lom_pkg::ST_BAD;
        end else if (c.op == lom_pkg::OP_SWAP) begin
          xl = ord_left[x];
          xr = ord_right[x];
          yl = ord_left[y];
          yr = ord_right[y];
          if (xr == y) begin
            link_ids(xl, y);
            link_ids(y, x);
            link_ids(x, yr);
          end else if (xl == y) begin
            link_ids(yl, x);
            link_ids(x, y);
            link_ids(y, xr);
          end else begin
            link_ids(xl, y);
            link_ids(y, xr);
            link_ids(yl, x);
            link_ids(x, yr);
          end
        end else begin
          link_ids(ord_left[x], ord_right[x]);
          // "right" in the current order is physical left when reversed
          if ((c.op == lom_pkg::OP_MOVE_RIGHT) != rev_q) begin
            nb = ord_right[y];
            link_ids(y, x);
            link_ids(x, nb);
          end else begin
            nb = ord_left[y];
            link_ids(nb, x);
            link_ids(x, y);
          end
        end
      end
      default: r.status = lom_pkg::ST_BAD;
    endcase
    // any accepted non-read op rewinds the cursor
    if (c.op != lom_pkg::OP_READ && r.status == lom_pkg::ST_OK)
      cursor = rev_q ? lom_pkg::RSENT : lom_pkg::LSENT;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random commands. Most operands are ids on the list so that moves and
  // swaps really rewire links; a few percent are raw noise.
  // ---------------------------------------------------------------------------
  function automatic logic [lom_pkg::ID_W-1:0] pick_live();
    return listed[$urandom_range(0, listed.size() - 1)];
  endfunction

  function automatic lom_pkg::in_item_t make_cmd(int unsigned cap,
                                                 int unsigned append_pct);
    lom_pkg::in_item_t        c;
    int unsigned              roll, pick;
    logic [lom_pkg::ID_W-1:0] v;
    roll     = $urandom_range(0, 99);
    pick     = $urandom_range(0, 99);
    c.op     = lom_pkg::OP_READ;
    c.item_x = lom_pkg::ITEM_W'($urandom);
    c.item_y = lom_pkg::ITEM_W'($urandom);
    if (read_run != 0) begin
      read_run--;
    end else if (roll < 6) begin
      c.op = lom_pkg::OP_W'($urandom_range(0, 2**lom_pkg::OP_W - 1));
    end else if (roll < 6 + append_pct || listed.size() < 2) begin
      c.op = lom_pkg::OP_APPEND;
      if (listed.size() < cap && listed.size() < lom_pkg::MAX_ITEMS) begin
        do v = lom_pkg::ID_W'($urandom_range(1, lom_pkg::MAX_ITEMS)); while (on_list[v]);
        c.item_x = v;
      end else if (pick < 70) begin
        c.item_x = pick_live();   // duplicate, or list full
      end
    end else begin
      c.item_x = pick_live();
      c.item_y = pick_live();
      // neighbors exercise the adjacent swap and trivial moves
      if (pick < 40) begin
        v = pick[0] ? ord_right[c.item_x] : ord_left[c.item_x];
        if (v != lom_pkg::LSENT && v != lom_pkg::RSENT) c.item_y = v;
      end else if (pick > 95) begin
        c.item_y = lom_pkg::ITEM_W'($urandom);
      end
      roll = $urandom_range(0, 99);
      if (roll < 22)      c.op = lom_pkg::OP_MOVE_RIGHT;
      else if (roll < 44) c.op = lom_pkg::OP_MOVE_LEFT;
      else if (roll < 64) c.op = lom_pkg::OP_SWAP;
      else if (roll < 72) c.op = lom_pkg::OP_REVERSE;
      else if (roll < 85) read_run = $urandom_range(1, cap < 20 ? cap + 2 : 20);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: holds the command until a transfer, predicts on the transfer edge,
  // then maybe idles for a burst.
  // ---------------------------------------------------------------------------
  task automatic push_cmd(lom_pkg::in_item_t c, logic typed,
                          lom_pkg::out_item_t canned);
    lom_pkg::out_item_t want;
    in_item  <= c;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    want = order_apply(c);
    if (typed) want = canned;
    pending_results.push_back(want);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic report(string msg);
    if (errors < SHOW_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  task automatic check_result(lom_pkg::out_item_t got);
    lom_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result %p", got));
      return;
    end
    want = pending_results.pop_front();
    if (got.read_value !== want.read_value)
      report($sformatf("read_value %0d, want %0d", got.read_value, want.read_value));
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.last_in_order !== want.last_in_order)
      report($sformatf("last_in_order %0b, want %0b", got.last_in_order,
                       want.last_in_order));
  endtask

  // Receiver: check each output transfer, then decide the stall for the
  // next cycle. A stall burst starts only rarely.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall_i) check_result(out_item);
    if (hold_cnt != 0) hold_cnt--;
    else if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct / 8 + 1)
      hold_cnt = $urandom_range(1, 17);
    out_stall_i <= (hold_cnt != 0);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_linked_order_move_swap_reverse_core failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed script: reset behavior, bad operands, every op, both swap
  // adjacency cases, append while reversed, and a read walk off the end.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [lom_pkg::OP_W-1:0]   op;
    logic [lom_pkg::ITEM_W-1:0] x;
    logic [lom_pkg::ITEM_W-1:0] y;
    logic                       typed;
    lom_pkg::out_item_t         want;
  } script_row_t;

  script_row_t script [26] = '{
    '{lom_pkg::OP_READ,       9'd0,   9'd0,   1'b1, R_PAST},  // empty list
    '{lom_pkg::OP_APPEND,     9'd257, 9'd0,   1'b1, R_BAD},   // id above range
    '{lom_pkg::OP_MOVE_RIGHT, 9'd1,   9'd2,   1'b1, R_BAD},   // ids not present
    '{OP_UNDEF_LO,            9'd1,   9'd2,   1'b1, R_BAD},
    '{OP_UNDEF_HI,            9'd511, 9'd511, 1'b1, R_BAD},
    '{lom_pkg::OP_APPEND,     9'd1,   9'd0,   1'b1, R_OK},
    '{lom_pkg::OP_APPEND,     9'd256, 9'd0,   1'b1, R_OK},
    '{lom_pkg::OP_APPEND,     9'd1,   9'd0,   1'b1, R_BAD},   // already present
    '{lom_pkg::OP_APPEND,     9'd2,   9'd0,   1'b1, R_OK},    // 1 256 2
    '{lom_pkg::OP_MOVE_RIGHT, 9'd1,   9'd1,   1'b1, R_BAD},   // x equals y
    '{lom_pkg::OP_MOVE_LEFT,  9'd1,   9'd300, 1'b1, R_BAD},
    '{lom_pkg::OP_SWAP,       9'd0,   9'd1,   1'b1, R_BAD},   // id zero
    '{lom_pkg::OP_SWAP,       9'd1,   9'd256, 1'b0, R_OK},    // y right after x
    '{lom_pkg::OP_SWAP,       9'd1,   9'd256, 1'b0, R_OK},    // y right before x
    '{lom_pkg::OP_SWAP,       9'd1,   9'd2,   1'b0, R_OK},    // apart
    '{lom_pkg::OP_MOVE_LEFT,  9'd1,   9'd2,   1'b0, R_OK},
    '{lom_pkg::OP_MOVE_RIGHT, 9'd1,   9'd256, 1'b0, R_OK},
    '{lom_pkg::OP_REVERSE,    9'd0,   9'd0,   1'b1, R_OK},
    '{lom_pkg::OP_APPEND,     9'd3,   9'd0,   1'b1, R_OK},    // lands at physical left
    '{lom_pkg::OP_MOVE_RIGHT, 9'd1,   9'd3,   1'b0, R_OK},
    '{lom_pkg::OP_READ,       9'd0,   9'd0,   1'b0, R_OK},
    '{lom_pkg::OP_READ,       9'd0,   9'd0,   1'b0, R_OK},
    '{lom_pkg::OP_READ,       9'd0,   9'd0,   1'b0, R_OK},
    '{lom_pkg::OP_READ,       9'd0,   9'd0,   1'b0, R_OK},
    '{lom_pkg::OP_READ,       9'd0,   9'd0,   1'b0, R_OK},    // past end
    '{lom_pkg::OP_READ,       9'd0,   9'd0,   1'b0, R_OK}     // starts over
  };

  initial begin
    int unsigned k;
    errors   = 0;
    cycles   = 0;
    gap_pct  = 0;
    hold_cnt = 0;
    read_run = 0;
    order_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 25;
    foreach (script[i])
      push_cmd(lom_pkg::in_item_t'{script[i].op, script[i].x, script[i].y},
               script[i].typed, script[i].want);

    // let the pipe run dry before the random part
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);

    // small list: dense rewiring, read bursts run past the end
    for (k = 0; k < 300; k++) begin
      gap_pct = ((k / 40) % 2 != 0) ? 0 : 35;
      push_cmd(make_cmd(12, 15), 1'b0, R_OK);
    end

    // grow to a full list, then hammer it; no idling at the tail of the run
    for (k = 0; k < 550; k++) begin
      if (k >= 400)              gap_pct = 0;
      else if ((k / 50) % 2 != 0) gap_pct = 40;
      else                        gap_pct = 10;
      push_cmd(make_cmd(lom_pkg::MAX_ITEMS, 55), 1'b0, R_OK);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb_linked_order_move_swap_reverse_core passed");
    end else begin
      $display("tb_linked_order_move_swap_reverse_core failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/lom_pkg.sv
design/lom_links.sv
design/lom_ctrl.sv
design/linked_order_move_swap_reverse_core.sv
design/lom_checker.sv
test/tb_linked_order_move_swap_reverse_core.sv
